### sv/tcb_pkg.sv
// ----------------------------------------------------------------------------
// tcb_pkg: shared types and constants for the target circle check core
// Register codes, configuration bundle, CORDIC lane type and arctangent table.
// ----------------------------------------------------------------------------
package tcb_pkg;

   // default number of CORDIC rotation cells
   localparam int CORDIC_STAGES_DEF = 16;

   // width of the CORDIC x/y lanes (covers the gain of about 1.65)
   localparam int CW = 30;

   // configuration register codes
   typedef enum logic [1:0] {
      CSR_CENTER_LAT     = 2'd0,
      CSR_CENTER_LON     = 2'd1,
      CSR_RADIUS_SQUARED = 2'd2,
      CSR_LON_FACTOR     = 2'd3
   } csr_addr_type;

   // configuration bundle seen by the datapath
   typedef struct packed {
      logic signed [23:0] center_lat;
      logic signed [24:0] center_lon;
      logic        [49:0] radius_squared;
      logic        [15:0] lon_factor;
   } tcb_cfg_type;

   // data moving down the chain of rotation cells
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic        [31:0]   z;
      logic                 in_circle;
      logic        [49:0]   dist_sq;
      logic                 zero;
   } tcb_cell_type;

   // atan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] atan_angle(input logic [4:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000003;
         5'd29: a = 32'h00000001;
         5'd30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

### sv/tcb_channels.sv
// ----------------------------------------------------------------------------
// tcb channels: valid/ready interfaces of the target circle check core
// Position request, result response and register write channels.
// ----------------------------------------------------------------------------
interface tcb_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] point_lat;
   logic signed [24:0] point_lon;
   logic        [15:0] expansion;
   modport source (output valid, point_lat, point_lon, expansion, input ready);
   modport sink   (input valid, point_lat, point_lon, expansion, output ready);
endinterface

interface tcb_rsp_if;
   logic        valid;
   logic        ready;
   logic        inside_res;
   logic [49:0] distance_squared;
   logic [15:0] bearing;
   modport source (output valid, inside_res, distance_squared, bearing, input ready);
   modport sink   (input valid, inside_res, distance_squared, bearing, output ready);
endinterface

interface tcb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [49:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/target_circle_check_and_bearing_core.sv
// ----------------------------------------------------------------------------
// target_circle_check_and_bearing_core: target circle check and bearing
// One transaction per cycle when rsp is ready.
// The pipeline holds five arithmetic stages plus one cell per CORDIC rotation.
// A stall on rsp holds the whole pipeline; rsp_valid rises as soon as a result exits.
// Synchronous reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module target_circle_check_and_bearing_core #(
   parameter int CORDIC_STAGES = tcb_pkg::CORDIC_STAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   tcb_req_if.sink   req,
   tcb_rsp_if.source rsp,
   tcb_csr_if.sink   csr
);
   localparam int DEPTH = CORDIC_STAGES + 5;

   tcb_pkg::tcb_cfg_type  cfg_ff;
   logic [DEPTH-1:0]      vld_ff;
   logic                  adv;
   tcb_pkg::tcb_cell_type chain [CORDIC_STAGES+1];
   logic [31:0]           z_rnd;

   // pipeline moves when the last slot is empty or being taken
   assign adv       = !vld_ff[DEPTH-1] || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_lat     <= '0;
         cfg_ff.center_lon     <= '0;
         cfg_ff.radius_squared <= '0;
         cfg_ff.lon_factor     <= 16'd32768;
      end else if (csr.valid) begin
         unique case (tcb_pkg::csr_addr_type'(csr.index))
            tcb_pkg::CSR_CENTER_LAT:     cfg_ff.center_lat     <= csr.data[23:0];
            tcb_pkg::CSR_CENTER_LON:     cfg_ff.center_lon     <= csr.data[24:0];
            tcb_pkg::CSR_RADIUS_SQUARED: cfg_ff.radius_squared <= csr.data;
            tcb_pkg::CSR_LON_FACTOR:     cfg_ff.lon_factor     <= csr.data[15:0];
         endcase
      end
   end

   // valid bits along the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req.valid};
      end
   end

   tcb_front u_front (
      .clock     (clock),
      .en        (adv),
      .cfg       (cfg_ff),
      .point_lat (req.point_lat),
      .point_lon (req.point_lon),
      .expansion (req.expansion),
      .cell_out  (chain[0])
   );

   // chain of rotation cells
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      tcb_cell #(.STAGE(g)) u_cell (
         .clock    (clock),
         .en       (adv),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   // round the binary angle to 16 bits, zero for a coincident point
   assign z_rnd = chain[CORDIC_STAGES].z + 32'h8000;

   assign rsp.valid            = vld_ff[DEPTH-1];
   assign rsp.inside_res       = chain[CORDIC_STAGES].in_circle;
   assign rsp.distance_squared = chain[CORDIC_STAGES].dist_sq;
   assign rsp.bearing          = chain[CORDIC_STAGES].zero ? 16'd0 : z_rnd[31:16];
endmodule

### sv/tcb_front.sv
// ----------------------------------------------------------------------------
// tcb_front: delta, scaling, distance and threshold pipeline
// Five registered stages ending in the CORDIC pre-rotation.
// ----------------------------------------------------------------------------
module tcb_front (
   input  logic                  clock,
   input  logic                  en,
   input  tcb_pkg::tcb_cfg_type  cfg,
   input  logic signed [23:0]    point_lat,
   input  logic signed [24:0]    point_lon,
   input  logic        [15:0]    expansion,
   output tcb_pkg::tcb_cell_type cell_out
);
   localparam int CW = tcb_pkg::CW;

   // stage 1: deltas
   logic signed [24:0] dlat1_ff;
   logic signed [25:0] dlon1_ff;
   logic        [15:0] exp1_ff;
   // stage 2: magnitudes and first products
   logic signed [24:0] dlat2_ff;
   logic        [24:0] a2_ff;
   logic               neg2_ff;
   logic        [41:0] prod2_ff;
   logic        [31:0] e2_2_ff;
   // stage 3: rounded longitude, squares, threshold partials
   logic signed [24:0] dlat3_ff;
   logic               neg3_ff;
   logic        [26:0] m3_ff;
   logic        [48:0] aa3_ff;
   logic        [49:0] phi3_ff;
   logic        [63:0] plo3_ff;
   // stage 4
   logic        [48:0] aa4_ff;
   logic        [53:0] mm4_ff;
   logic        [58:0] thr4_ff;
   logic signed [CW-1:0] x4_ff;
   logic signed [CW-1:0] y4_ff;
   logic               zero4_ff;
   // stage 5 output
   tcb_pkg::tcb_cell_type cell_ff, cell_in;

   logic [25:0] dlon_mag;
   logic [41:0] prod_rnd;
   logic signed [CW-1:0] m_ext;
   logic [54:0] dist_sum;

   assign dlon_mag = dlon1_ff[25] ? 26'(-dlon1_ff) : 26'(dlon1_ff);
   assign prod_rnd = prod2_ff + 42'd16384;
   assign m_ext    = $signed({3'b000, m3_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         dlat1_ff <= $signed({cfg.center_lat[23], cfg.center_lat})
                   - $signed({point_lat[23], point_lat});
         dlon1_ff <= $signed({cfg.center_lon[24], cfg.center_lon})
                   - $signed({point_lon[24], point_lon});
         exp1_ff  <= expansion;

         dlat2_ff <= dlat1_ff;
         a2_ff    <= dlat1_ff[24] ? 25'(-dlat1_ff) : 25'(dlat1_ff);
         neg2_ff  <= dlon1_ff[25];
         prod2_ff <= 42'(dlon_mag) * 42'(cfg.lon_factor);
         e2_2_ff  <= 32'(exp1_ff) * 32'(exp1_ff);

         dlat3_ff <= dlat2_ff;
         neg3_ff  <= neg2_ff;
         m3_ff    <= prod_rnd[41:15];
         aa3_ff   <= 49'(a2_ff) * 49'(a2_ff);
         phi3_ff  <= 50'(cfg.radius_squared[49:32]) * 50'(e2_2_ff);
         plo3_ff  <= 64'(cfg.radius_squared[31:0]) * 64'(e2_2_ff);

         aa4_ff   <= aa3_ff;
         mm4_ff   <= 54'(m3_ff) * 54'(m3_ff);
         thr4_ff  <= {1'b0, phi3_ff, 8'd0} + 59'(plo3_ff[63:24]);
         x4_ff    <= CW'(dlat3_ff);
         y4_ff    <= neg3_ff ? -m_ext : m_ext;
         zero4_ff <= (dlat3_ff == 25'sd0) && (m3_ff == 27'd0);

         cell_ff  <= cell_in;
      end
   end

   // stage 5: distance, inside test, saturation and half-plane pre-rotation
   assign dist_sum = 55'(aa4_ff) + 55'(mm4_ff);

   always_comb begin
      cell_in.in_circle = 59'(dist_sum) <= thr4_ff;
      cell_in.dist_sq   = (dist_sum[54:50] != 5'd0) ? {50{1'b1}} : dist_sum[49:0];
      cell_in.zero      = zero4_ff;
      if (x4_ff < 0) begin
         cell_in.x = -x4_ff;
         cell_in.y = -y4_ff;
         cell_in.z = 32'h80000000;
      end else begin
         cell_in.x = x4_ff;
         cell_in.y = y4_ff;
         cell_in.z = 32'h0;
      end
   end

   assign cell_out = cell_ff;
endmodule

### sv/tcb_cell.sv
// ----------------------------------------------------------------------------
// tcb_cell: one vectoring CORDIC rotation cell
// Rotates toward the x axis by atan(2^-STAGE) and carries the side data.
// ----------------------------------------------------------------------------
module tcb_cell #(
   parameter int STAGE = 0
) (
   input  logic                  clock,
   input  logic                  en,
   input  tcb_pkg::tcb_cell_type cell_in,
   output tcb_pkg::tcb_cell_type cell_out
);
   localparam int CW = tcb_pkg::CW;

   tcb_pkg::tcb_cell_type cell_ff, cell_nx_in;
   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;
   logic [31:0] ang;

   assign xs  = cell_in.x >>> STAGE;
   assign ys  = cell_in.y >>> STAGE;
   assign ang = tcb_pkg::atan_angle(5'(STAGE));

   // micro-rotation in the direction that drives y toward zero
   always_comb begin
      cell_nx_in = cell_in;
      if (cell_in.y > 0) begin
         cell_nx_in.x = cell_in.x + ys;
         cell_nx_in.y = cell_in.y - xs;
         cell_nx_in.z = cell_in.z + ang;
      end else begin
         cell_nx_in.x = cell_in.x - ys;
         cell_nx_in.y = cell_in.y + xs;
         cell_nx_in.z = cell_in.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_nx_in;
      end
   end

   assign cell_out = cell_ff;
endmodule
